FILE: hdl/lac_pkg.sv
// lac_pkg: shared types and constants for the lru associative cache unit
// request/response structs, opcode and sequencer state enums, default sizes
// no dependencies
`default_nettype none

package lac_pkg;

	// default sizes for the top level parameters
	localparam int SLOTS_DEF     = 16;
	localparam int KEY_BITS_DEF  = 32;
	localparam int DATA_BITS_DEF = 32;

	// fixed widths and the reset capacity
	localparam int STAMP_BITS = 48;
	localparam int CFG_BITS   = 5;
	localparam int CAP_RESET  = 16;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_PROBE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] key_tag;
		logic [31:0] new_payload;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] payload_out;
		logic        evicted;
		logic [3:0]  slot_used;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic                we;
		logic [CFG_BITS-1:0] value;
	} cfg_wr_t;

endpackage

`default_nettype wire

FILE: hdl/lac_entry_ram.sv
// lac_entry_ram: one-write one-read synchronous memory for cache entries
// holds key, payload and stamp of every slot; registered read data
// no dependencies
`default_nettype none

module lac_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 112
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered when re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/lac_engine.sv
// lac_engine: request sequencer, entry scan and write-back for the lru cache
// keeps valid bits, capacity and access counter; entries live in lac_entry_ram
// depends on lac_pkg and lac_entry_ram
`default_nettype none

module lac_engine import lac_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire req_t    req,
	input  wire cfg_wr_t cfg,
	output logic         rsp_valid,
	input  wire logic    rsp_take,
	output rsp_t         rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = KEY_BITS + DATA_BITS + STAMP_BITS;

	state_t                st_q, st_d;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [DATA_BITS-1:0]  data_q;
	logic [CW-1:0]         cap_q, cap_new;
	logic [SLOTS-1:0]      valid_q;
	logic [STAMP_BITS-1:0] acc_q, new_stamp;

	// scan state
	logic [CW-1:0]         iss_q;
	logic                  pend_s1;
	logic [IW-1:0]         idx_s1;
	logic                  hit_found_q, lru_found_q, free_found_q;
	logic [IW-1:0]         hit_idx_q, lru_idx_q, free_idx_q;
	logic [DATA_BITS-1:0]  hit_pay_q;
	logic [STAMP_BITS-1:0] lru_stamp_q;
	logic [CW-1:0]         cnt_q;

	// memory side
	logic                  rd_en, wr_en;
	logic [IW-1:0]         waddr;
	logic [EW-1:0]         wdata, rdata;
	logic [KEY_BITS-1:0]   rd_key;
	logic [DATA_BITS-1:0]  rd_pay;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic                  e_valid, e_match;

	// write-back decisions
	logic                  accept, adv, bump, set_valid, full;
	logic [IW-1:0]         slot;
	logic [CW-1:0]         occ;

	lac_entry_ram #(
		.DEPTH (SLOTS),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (iss_q[IW-1:0]),
		.rdata (rdata)
	);

	assign rd_key   = rdata[EW-1 -: KEY_BITS];
	assign rd_pay   = rdata[STAMP_BITS +: DATA_BITS];
	assign rd_stamp = rdata[STAMP_BITS-1:0];
	assign e_valid  = valid_q[idx_s1];
	assign e_match  = e_valid && (rd_key == key_q);

	// handshakes
	assign req_ready = (st_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (st_q == ST_WRITE);
	assign adv       = rsp_valid && rsp_take;
	assign rd_en     = (st_q == ST_SCAN) && (iss_q != cap_q);

	// capacity clamp for a register write
	always_comb begin
		int v;
		v = int'(cfg.value);
		if (v < 1) begin
			v = 1;
		end else if (v > SLOTS) begin
			v = SLOTS;
		end
		cap_new = CW'(v);
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = (req.opcode == OP_CLEAR) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (iss_q == cap_q) begin
					st_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (rsp_take) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// result and write-back from the scan summary
	always_comb begin
		rsp       = '0;
		wr_en     = 1'b0;
		bump      = 1'b0;
		set_valid = 1'b0;
		slot      = '0;
		occ       = cnt_q;
		full      = (cnt_q >= cap_q);
		new_stamp = acc_q + 1'b1;
		waddr     = hit_idx_q;
		wdata     = {key_q, hit_pay_q, new_stamp};
		if (op_q == OP_CLEAR) begin
			occ = '0;
		end else if (hit_found_q) begin
			rsp.hit = 1'b1;
			slot    = hit_idx_q;
			if (op_q != OP_PROBE) begin
				wr_en = rsp_valid;
				bump  = 1'b1;
			end
			if (op_q == OP_LOOKUP) begin
				rsp.payload_out = 32'(hit_pay_q);
			end
		end else if (op_q == OP_INSERT) begin
			if (full) begin
				slot        = lru_idx_q;
				rsp.evicted = 1'b1;
			end else begin
				slot = free_idx_q;
				occ  = CW'(cnt_q + 1'b1);
			end
			waddr     = slot;
			wdata     = {key_q, data_q, new_stamp};
			wr_en     = rsp_valid;
			bump      = 1'b1;
			set_valid = 1'b1;
		end
		rsp.slot_used = 4'(slot);
		rsp.occupancy = 5'(occ);
	end

	// capacity, valid bits and access counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'((CAP_RESET > SLOTS) ? SLOTS : CAP_RESET);
			valid_q <= '0;
			acc_q   <= '0;
		end else begin
			if (cfg.we) begin
				cap_q <= cap_new;
				for (int i = 0; i < SLOTS; i++) begin
					if (i >= int'(cap_new)) begin
						valid_q[i] <= 1'b0;
					end
				end
			end else if (adv) begin
				if (op_q == OP_CLEAR) begin
					valid_q <= '0;
				end else if (set_valid) begin
					valid_q[slot] <= 1'b1;
				end
				if (bump) begin
					acc_q <= new_stamp;
				end
			end
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else if (accept) begin
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			pend_s1 <= rd_en;
			if (rd_en) begin
				iss_q <= CW'(iss_q + 1'b1);
			end
			if (pend_s1) begin
				if (e_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (e_valid) begin
					lru_found_q <= 1'b1;
					cnt_q       <= CW'(cnt_q + 1'b1);
				end
				if (!e_valid) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// request capture and scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			key_q  <= KEY_BITS'(req.key_tag);
			data_q <= DATA_BITS'(req.new_payload);
		end
		if (rd_en) begin
			idx_s1 <= iss_q[IW-1:0];
		end
		if (pend_s1 && !accept) begin
			if (e_match && !hit_found_q) begin
				hit_idx_q <= idx_s1;
				hit_pay_q <= rd_pay;
			end
			// strict compare keeps the lowest index on equal stamps
			if (e_valid && (!lru_found_q || (rd_stamp < lru_stamp_q))) begin
				lru_idx_q   <= idx_s1;
				lru_stamp_q <= rd_stamp;
			end
			if (!e_valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

`ifndef SYNTHESIS
	a_valid_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= int'(cap_q))
		else $error("valid entries exceed capacity");

	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> $countones(valid_q) == int'($past(occ)))
		else $error("reported occupancy differs from valid bits");

	a_counter_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_WRITE) |=> acc_q == $past(acc_q))
		else $error("access counter moved outside write-back");

	a_evict_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rsp.evicted) |-> valid_q[lru_idx_q])
		else $error("eviction of an invalid slot");
`endif

endmodule

`default_nettype wire

FILE: hdl/lru_assoc_cache_unit.sv
// lru_assoc_cache_unit: fully associative cache with least-recently-used replacement
//
// Requests enter on req_valid/req_ready with opcode, key_tag and new_payload;
// responses leave on rsp_valid/rsp_ready with hit, payload_out, evicted,
// slot_used and occupancy. Exactly one response per request, in order.
// cfg_we/cfg_wdata write capacity_in_use (clamped to 1..SLOTS); it must be written
// only while no request is in flight (the block does not enforce this), and a write
// drops every slot at or above it. A clear request goes from accept straight to
// write-back. Other requests scan the entry memory one slot per cycle over
// capacity_in_use slots, then enter write-back, which waits for the output
// register. A new request is accepted only after the last one leaves write-back.
// The scan through the single read port of the entry memory sets the pace.
// Reset empties the cache, clears the access counter and sets capacity to
// min(16, SLOTS); no memory clearing pass is needed.
// A response waits in an output register while rsp_ready is low; the next
// request is still accepted and scanned, and stalls at write-back only.
// depends on lac_pkg, lac_engine, lac_entry_ram
`default_nettype none

module lru_assoc_cache_unit import lac_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire req_t                req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output rsp_t                     rsp,
	input  wire logic                cfg_we,
	input  wire logic [CFG_BITS-1:0] cfg_wdata
);

	cfg_wr_t cfg;
	logic    eng_valid, eng_take;
	rsp_t    eng_rsp;
	logic    rsp_valid_q;
	rsp_t    rsp_q;

	assign cfg.we    = cfg_we;
	assign cfg.value = cfg_wdata;

	lac_engine #(
		.SLOTS     (SLOTS),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg       (cfg),
		.rsp_valid (eng_valid),
		.rsp_take  (eng_take),
		.rsp       (eng_rsp)
	);

	// output register takes a response when empty or being drained
	assign eng_take = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_take) begin
			rsp_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_take && eng_valid) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for lru_assoc_cache_unit, a table of directed requests then
// random traffic under several capacities, each response checked against a typed result or a cache model
// depends on lac_pkg and lru_assoc_cache_unit

module tb_top;
	import lac_pkg::*;

	localparam int MODEL_SLOTS  = SLOTS_DEF;
	localparam int STALL_LIMIT  = 4000;
	localparam int CHUNK_ITEMS  = 50;
	localparam int CHUNKS       = 9;
	localparam int POOL_KEYS    = 24;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CFG_BITS-1:0] cap;
		req_t                rq;
		bit                  typed;
		rsp_t                rs;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp;
	logic                cfg_we;
	logic [CFG_BITS-1:0] cfg_wdata;

	// cache model state
	bit                    cache_valid [MODEL_SLOTS];
	bit [31:0]             cache_key   [MODEL_SLOTS];
	bit [31:0]             cache_data  [MODEL_SLOTS];
	bit [STAMP_BITS-1:0]   cache_stamp [MODEL_SLOTS];
	bit [STAMP_BITS-1:0]   use_count;
	int                    cap_model;

	rsp_t      access_results [$];
	bit [31:0] key_pool [POOL_KEYS];
	int        err_count;
	int        tx_gap;
	int        rx_gap;
	int        idle_cycles;

	lru_assoc_cache_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// directed requests: typed results where obvious, model results elsewhere
	plan_row_t plan [24] = '{
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd0, 5'd0}},
		'{ROW_REQ, 5'd0, '{OP_PROBE,  32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd0, 5'd0}},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd0, 5'd1}},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd1, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 4'd0, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 4'd1, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_PROBE,  32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 4'd0, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'h0000_0000, 32'h1234_5678}, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 4'd0, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 4'd0, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_CLEAR,  32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd0, 5'd0}},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 4'd0, 5'd0}},
		'{ROW_CFG, 5'd2, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'hA5A5_A5A5, 32'h1111_1111}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'h5A5A_5A5A, 32'h2222_2222}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000}, 1'b0, '0},
		// full at capacity two: the older entry in slot one goes
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'h3C3C_3C3C, 32'h3333_3333}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b1, 4'd1, 5'd2}},
		'{ROW_REQ, 5'd0, '{OP_PROBE,  32'h5A5A_5A5A, 32'h0000_0000}, 1'b0, '0},
		// zero capacity is taken as one
		'{ROW_CFG, 5'd0, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'hC3C3_C3C3, 32'h4444_4444}, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b1, 4'd0, 5'd1}},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000}, 1'b0, '0},
		// above the slot count is taken as sixteen
		'{ROW_CFG, 5'd31, '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_INSERT, 32'h0000_0000, 32'hDEAD_BEEF}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_LOOKUP, 32'hC3C3_C3C3, 32'h0000_0000}, 1'b0, '0},
		'{ROW_REQ, 5'd0, '{OP_PROBE,  32'h0000_0000, 32'h0000_0000}, 1'b0, '0}
	};

	// valid entries below the capacity
	function automatic int occupied();
		int n;
		n = 0;
		for (int i = 0; i < cap_model; i++)
			if (cache_valid[i])
				n++;
		return n;
	endfunction

	// capacity write: clamp to 1..slots, drop entries at or above it
	task automatic model_cap_write(input logic [CFG_BITS-1:0] value);
		cap_model = int'(value);
		if (cap_model < 1)
			cap_model = 1;
		if (cap_model > MODEL_SLOTS)
			cap_model = MODEL_SLOTS;
		for (int i = cap_model; i < MODEL_SLOTS; i++)
			cache_valid[i] = 1'b0;
	endtask

	// one cache access: match, restamp, lru eviction and fill
	task automatic cache_access(input req_t rq, output rsp_t rs);
		int  hit_idx;
		int  lru;
		int  free_idx;
		bit  found;
		rs = '0;
		if (rq.opcode == OP_CLEAR) begin
			for (int i = 0; i < MODEL_SLOTS; i++)
				cache_valid[i] = 1'b0;
		end else begin
			hit_idx = -1;
			for (int i = 0; i < cap_model; i++)
				if (hit_idx < 0 && cache_valid[i] && cache_key[i] == rq.key_tag)
					hit_idx = i;
			if (hit_idx >= 0) begin
				rs.hit = 1'b1;
				rs.slot_used = hit_idx[3:0];
				if (rq.opcode != OP_PROBE) begin
					use_count = use_count + 1'b1;
					cache_stamp[hit_idx] = use_count;
				end
				if (rq.opcode == OP_LOOKUP)
					rs.payload_out = cache_data[hit_idx];
			end else if (rq.opcode == OP_INSERT) begin
				// full: drop the oldest stamp, lowest slot on ties
				if (occupied() >= cap_model) begin
					found = 1'b0;
					lru = 0;
					for (int i = 0; i < cap_model; i++)
						if (cache_valid[i] && (!found || cache_stamp[i] < cache_stamp[lru])) begin
							lru = i;
							found = 1'b1;
						end
					if (found) begin
						cache_valid[lru] = 1'b0;
						rs.evicted = 1'b1;
					end
				end
				free_idx = -1;
				for (int i = 0; i < cap_model; i++)
					if (free_idx < 0 && !cache_valid[i])
						free_idx = i;
				if (free_idx < 0)
					free_idx = 0;
				use_count = use_count + 1'b1;
				cache_valid[free_idx] = 1'b1;
				cache_key[free_idx]   = rq.key_tag;
				cache_data[free_idx]  = rq.new_payload;
				cache_stamp[free_idx] = use_count;
				rs.slot_used = free_idx[3:0];
			end
		end
		rs.occupancy = 5'(occupied());
	endtask

	// present one request from a falling edge, record its result on accept
	task automatic send_request(input req_t rq, input bit typed, input rsp_t typed_rs);
		rsp_t predicted;
		while ($urandom_range(99) < tx_gap) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= rq;
		do
			@(posedge clk);
		while (!req_ready);
		cache_access(rq, predicted);
		access_results.push_back(typed ? typed_rs : predicted);
		@(negedge clk);
	endtask

	// capacity write once the cache has drained
	task automatic write_capacity(input logic [CFG_BITS-1:0] value);
		req_valid <= 1'b0;
		while (access_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		model_cap_write(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_result(input rsp_t want, input rsp_t got);
		if (got.hit !== want.hit) begin
			$display("%0t: hit expected %0h got %0h", $time, want.hit, got.hit);
			err_count++;
		end
		if (got.payload_out !== want.payload_out) begin
			$display("%0t: payload_out expected %08h got %08h", $time,
				want.payload_out, got.payload_out);
			err_count++;
		end
		if (got.evicted !== want.evicted) begin
			$display("%0t: evicted expected %0h got %0h", $time, want.evicted, got.evicted);
			err_count++;
		end
		if (got.slot_used !== want.slot_used) begin
			$display("%0t: slot_used expected %0d got %0d", $time,
				want.slot_used, got.slot_used);
			err_count++;
		end
		if (got.occupancy !== want.occupancy) begin
			$display("%0t: occupancy expected %0d got %0d", $time,
				want.occupancy, got.occupancy);
			err_count++;
		end
	endtask

	// response side: random stalls, compare against the oldest expectation
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rx_gap);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (access_results.size() == 0) begin
				$display("%0t: response with none expected, got %0h", $time, rsp);
				err_count++;
			end else begin
				check_result(access_results.pop_front(), rsp);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		req_t                rq;
		op_t                 op;
		int                  pick;
		int                  span;
		logic [CFG_BITS-1:0] cap_value;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_count = 0;
		idle_cycles = 0;
		tx_gap = 29;
		rx_gap = 61;
		for (int i = 0; i < MODEL_SLOTS; i++) begin
			cache_valid[i] = 1'b0;
			cache_key[i]   = '0;
			cache_data[i]  = '0;
			cache_stamp[i] = '0;
		end
		use_count = '0;
		cap_model = CAP_RESET;
		for (int i = 0; i < POOL_KEYS; i++)
			key_pool[i] = $urandom;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_capacity(plan[i].cap);
			else
				send_request(plan[i].rq, plan[i].typed, plan[i].rs);
		end

		// random traffic, capacity changed per chunk, idling pattern per third
		for (int c = 0; c < CHUNKS; c++) begin
			if (c == CHUNKS / 3) begin
				tx_gap = 61;
				rx_gap = 29;
			end else if (c == 2 * CHUNKS / 3) begin
				tx_gap = 0;
				rx_gap = 0;
			end
			if ($urandom_range(3) == 0)
				cap_value = CFG_BITS'($urandom_range(31));
			else
				cap_value = CFG_BITS'($urandom_range(1, 16));
			write_capacity(cap_value);
			span = cap_model + 3;
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 4)
					op = OP_CLEAR;
				else if (pick < 42)
					op = OP_INSERT;
				else if (pick < 76)
					op = OP_LOOKUP;
				else
					op = OP_PROBE;
				rq.opcode = op;
				if ($urandom_range(9) == 0)
					rq.key_tag = $urandom;
				else
					rq.key_tag = key_pool[$urandom_range(span - 1)];
				rq.new_payload = $urandom;
				send_request(rq, 1'b0, '0);
			end
		end

		// drain and settle
		req_valid <= 1'b0;
		while (access_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/lac_pkg.sv
hdl/lac_entry_ram.sv
hdl/lac_engine.sv
hdl/lru_assoc_cache_unit.sv
dv/tb_top.sv
